>>> rtl/core/wrcp_pkg.sv
// wrcp_pkg: types, character codes and lookup functions for the wifi response parser
// no dependencies; used by every module in rtl/core
`timescale 1ns / 1ps

package wrcp_pkg;

  localparam int unsigned CRED_CAPACITY = 64;
  localparam logic [7:0]  RETRY_THRESHOLD_RST = 8'd2;

  // received characters
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_X     = 8'h58;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_OK        = 3'd1,
    EV_RECOVER   = 3'd2,
    EV_CRED_BYTE = 3'd3,
    EV_CRED_DONE = 3'd4,
    EV_SET_DONE  = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_O     = 4'd1,
    ST_E     = 4'd2,
    ST_ER    = 4'd3,
    ST_ERR   = 4'd4,
    ST_ERRO  = 4'd5,
    ST_CRED1 = 4'd6,
    ST_CRED2 = 4'd7,
    ST_QM    = 4'd8,
    ST_QQ    = 4'd9,
    ST_SET   = 4'd10
  } state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] send_attempts;
    logic       recovery_blocked;
  } in_t;

  typedef struct packed {
    event_e      event_res;
    logic [4:0]  setting_code;
    logic [23:0] setting_value;
    logic [1:0]  value_length;
    logic [7:0]  cred_byte;
    logic [5:0]  cred_index;
    logic [6:0]  cred_length;
    logic        cred_overflow;
    logic        wifi_ok;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] sel;
  } letter_t;

  // setting letter after ?Q -> setting index (code minus one)
  function automatic letter_t letter_lookup(logic [7:0] c);
    letter_t r;
    r.hit = 1'b1;
    r.sel = 4'd0;
    case (c)
      CH_P:    r.sel = 4'd0;
      CH_W:    r.sel = 4'd1;
      CH_V:    r.sel = 4'd2;
      CH_D:    r.sel = 4'd3;
      CH_M:    r.sel = 4'd4;
      CH_C:    r.sel = 4'd5;
      CH_G:    r.sel = 4'd6;
      CH_A:    r.sel = 4'd7;
      CH_I:    r.sel = 4'd8;
      CH_F:    r.sel = 4'd9;
      CH_R:    r.sel = 4'd10;
      CH_T:    r.sel = 4'd11;
      CH_L:    r.sel = 4'd12;
      CH_Y:    r.sel = 4'd13;
      CH_J:    r.sel = 4'd14;
      CH_X:    r.sel = 4'd15;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // number of value bytes per setting
  function automatic logic [1:0] setting_len(logic [3:0] sel);
    logic [1:0] n;
    unique case (sel)
      4'd1, 4'd2, 4'd8, 4'd9, 4'd11, 4'd12: n = 2'd3;
      4'd14, 4'd15:                         n = 2'd2;
      default:                              n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/wrcp_in_if.sv
// wrcp_in_if: valid/ready channel carrying one received word
// depends on wrcp_pkg for nothing but shares the field widths of in_t
`timescale 1ns / 1ps

interface wrcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] send_attempts;
  logic       recovery_blocked;

  modport source (output valid, rx_byte, send_attempts, recovery_blocked, input ready);
  modport sink   (input valid, rx_byte, send_attempts, recovery_blocked, output ready);
endinterface

>>> rtl/core/wrcp_out_if.sv
// wrcp_out_if: valid/ready channel carrying one parser result word
// field widths follow wrcp_pkg::result_t
`timescale 1ns / 1ps

interface wrcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [4:0]  setting_code;
  logic [23:0] setting_value;
  logic [1:0]  value_length;
  logic [7:0]  cred_byte;
  logic [5:0]  cred_index;
  logic [6:0]  cred_length;
  logic        cred_overflow;
  logic        wifi_ok;

  modport source (output valid, event_res, setting_code, setting_value, value_length,
                  cred_byte, cred_index, cred_length, cred_overflow, wifi_ok,
                  input ready);
  modport sink   (input valid, event_res, setting_code, setting_value, value_length,
                  cred_byte, cred_index, cred_length, cred_overflow, wifi_ok,
                  output ready);
endinterface

>>> rtl/core/wrcp_core.sv
// wrcp_core: input register, parser state and the single-pass step logic
// depends on wrcp_pkg
`timescale 1ns / 1ps

module wrcp_core #(
  parameter int unsigned CredCapacity = wrcp_pkg::CRED_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wrcp_pkg::in_t     in_data_i,
  input  logic [7:0]        thr_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output wrcp_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(CredCapacity + 1);
  localparam logic [CntW-1:0] CapFull = CntW'(CredCapacity);

  logic                in_valid_q;
  wrcp_pkg::in_t       in_data_q;
  wrcp_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [23:0]         acc_q, acc_d;
  logic                rdy_q, rdy_d;
  logic                ovf_q, ovf_d;
  logic [3:0]          sel_q, sel_d;

  logic                fire;
  logic [7:0]          b;
  logic                cap_full;
  logic                rec_hit;
  logic [23:0]         acc_new;
  logic [1:0]          need;
  logic [CntW-1:0]     cnt_inc;
  logic                set_done;
  wrcp_pkg::letter_t   letter;

  assign fire        = in_valid_q && res_ready_i;
  assign in_ready_o  = !in_valid_q || res_ready_i;
  assign res_valid_o = in_valid_q;

  assign b        = in_data_q.rx_byte;
  assign cap_full = cnt_q >= CapFull;
  assign rec_hit  = (b == wrcp_pkg::CH_R) && (in_data_q.send_attempts > thr_i)
                    && !in_data_q.recovery_blocked;
  assign acc_new  = {acc_q[15:0], b};
  assign need     = wrcp_pkg::setting_len(sel_q);
  assign cnt_inc  = cnt_q + CntW'(1);
  assign set_done = cnt_inc >= CntW'(need);
  assign letter   = wrcp_pkg::letter_lookup(b);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rdy_d   = rdy_q;
    ovf_d   = ovf_q;
    sel_d   = sel_q;
    unique case (state_q)
      wrcp_pkg::ST_IDLE: begin
        if (b == wrcp_pkg::CH_O || b == wrcp_pkg::CH_AT) state_d = wrcp_pkg::ST_O;
        else if (b == wrcp_pkg::CH_E)                    state_d = wrcp_pkg::ST_E;
        else if (b == wrcp_pkg::CH_QMARK)                state_d = wrcp_pkg::ST_QM;
      end
      wrcp_pkg::ST_O: begin
        state_d = wrcp_pkg::ST_IDLE;
        if (b == wrcp_pkg::CH_K) begin
          rdy_d = 1'b1;
        end else if (b == wrcp_pkg::CH_P) begin
          state_d = wrcp_pkg::ST_CRED1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      wrcp_pkg::ST_E:
        state_d = (b == wrcp_pkg::CH_R) ? wrcp_pkg::ST_ER : wrcp_pkg::ST_IDLE;
      wrcp_pkg::ST_ER:
        state_d = (b == wrcp_pkg::CH_R) ? wrcp_pkg::ST_ERR : wrcp_pkg::ST_IDLE;
      wrcp_pkg::ST_ERR:
        state_d = (b == wrcp_pkg::CH_O) ? wrcp_pkg::ST_ERRO : wrcp_pkg::ST_IDLE;
      wrcp_pkg::ST_ERRO: begin
        state_d = wrcp_pkg::ST_IDLE;
        if (rec_hit) rdy_d = 1'b0;
      end
      wrcp_pkg::ST_CRED1: begin
        if (cap_full) ovf_d = 1'b1;
        else          cnt_d = cnt_inc;
        // first comma advances even when dropped
        if (b == wrcp_pkg::CH_COMMA) state_d = wrcp_pkg::ST_CRED2;
      end
      wrcp_pkg::ST_CRED2: begin
        if (b == wrcp_pkg::CH_COMMA) begin
          cnt_d   = '0;
          state_d = wrcp_pkg::ST_IDLE;
        end else if (cap_full) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      wrcp_pkg::ST_QM:
        state_d = (b == wrcp_pkg::CH_Q) ? wrcp_pkg::ST_QQ : wrcp_pkg::ST_IDLE;
      wrcp_pkg::ST_QQ: begin
        state_d = letter.hit ? wrcp_pkg::ST_SET : wrcp_pkg::ST_IDLE;
        sel_d   = letter.sel;
        cnt_d   = '0;
        acc_d   = '0;
      end
      wrcp_pkg::ST_SET: begin
        if (set_done) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = wrcp_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_inc;
          acc_d = acc_new;
        end
      end
      default: state_d = wrcp_pkg::ST_IDLE;
    endcase
  end

  // result word
  always_comb begin
    res_o           = '0;
    res_o.event_res = wrcp_pkg::EV_NONE;
    unique case (state_q)
      wrcp_pkg::ST_O:
        if (b == wrcp_pkg::CH_K) res_o.event_res = wrcp_pkg::EV_OK;
      wrcp_pkg::ST_ERRO:
        if (rec_hit) res_o.event_res = wrcp_pkg::EV_RECOVER;
      wrcp_pkg::ST_CRED1: begin
        if (!cap_full) begin
          res_o.event_res  = wrcp_pkg::EV_CRED_BYTE;
          res_o.cred_byte  = b;
          res_o.cred_index = 6'(cnt_q);
        end
      end
      wrcp_pkg::ST_CRED2: begin
        if (b == wrcp_pkg::CH_COMMA) begin
          res_o.event_res   = wrcp_pkg::EV_CRED_DONE;
          res_o.cred_length = 7'(cnt_q);
        end else if (!cap_full) begin
          res_o.event_res  = wrcp_pkg::EV_CRED_BYTE;
          res_o.cred_byte  = b;
          res_o.cred_index = 6'(cnt_q);
        end
      end
      wrcp_pkg::ST_SET: begin
        if (set_done) begin
          res_o.event_res     = wrcp_pkg::EV_SET_DONE;
          res_o.setting_code  = 5'(sel_q) + 5'd1;
          res_o.setting_value = acc_new;
          res_o.value_length  = need;
        end
      end
      default: res_o.event_res = wrcp_pkg::EV_NONE;
    endcase
    res_o.cred_overflow = ovf_d;
    res_o.wifi_ok       = rdy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= wrcp_pkg::ST_IDLE;
      cnt_q      <= '0;
      acc_q      <= '0;
      rdy_q      <= 1'b0;
      ovf_q      <= 1'b0;
      sel_q      <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        rdy_q   <= rdy_d;
        ovf_q   <= ovf_d;
        sel_q   <= sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_data_q <= in_data_i;
  end

endmodule

>>> rtl/core/wrcp_out_buf.sv
// wrcp_out_buf: result register with a skid entry so upstream ready is registered
// depends on wrcp_pkg
`timescale 1ns / 1ps

module wrcp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  wrcp_pkg::result_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output wrcp_pkg::result_t pop_data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  wrcp_pkg::result_t out_data_q;
  wrcp_pkg::result_t skid_data_q;
  logic              push;
  logic              advance;

  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && push_ready_o;
  assign advance      = pop_ready_i || !out_valid_q;
  assign pop_valid_o  = out_valid_q;
  assign pop_data_o   = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push) begin
      skid_data_q <= push_data_i;
    end
  end

endmodule

>>> rtl/core/wifi_response_command_parser_unit.sv
// a word accepted sits in the input register, and its result is loaded into the
// result register, where the sink can take it; throughput: one word per cycle
// while the sink keeps taking results and the output buffer does not fill
// reset: parser idle, counters, ready and overflow flags cleared, retry
// threshold set to 2; a two-entry output buffer keeps input ready registered
`timescale 1ns / 1ps

module wifi_response_command_parser_unit #(
  parameter int unsigned CredCapacity = wrcp_pkg::CRED_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrcp_in_if.sink    rx_i,
  wrcp_out_if.source res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0]        thr_q;
  wrcp_pkg::in_t     in_data;
  logic              core_valid;
  logic              core_ready;
  wrcp_pkg::result_t core_res;
  wrcp_pkg::result_t buf_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= wrcp_pkg::RETRY_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign in_data.rx_byte          = rx_i.rx_byte;
  assign in_data.send_attempts    = rx_i.send_attempts;
  assign in_data.recovery_blocked = rx_i.recovery_blocked;

  wrcp_core #(
    .CredCapacity(CredCapacity)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .in_data_i   (in_data),
    .thr_i       (thr_q),
    .res_valid_o (core_valid),
    .res_ready_i (core_ready),
    .res_o       (core_res)
  );

  wrcp_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (core_valid),
    .push_ready_o (core_ready),
    .push_data_i  (core_res),
    .pop_valid_o  (res_o.valid),
    .pop_ready_i  (res_o.ready),
    .pop_data_o   (buf_res)
  );

  assign res_o.event_res     = buf_res.event_res;
  assign res_o.setting_code  = buf_res.setting_code;
  assign res_o.setting_value = buf_res.setting_value;
  assign res_o.value_length  = buf_res.value_length;
  assign res_o.cred_byte     = buf_res.cred_byte;
  assign res_o.cred_index    = buf_res.cred_index;
  assign res_o.cred_length   = buf_res.cred_length;
  assign res_o.cred_overflow = buf_res.cred_overflow;
  assign res_o.wifi_ok       = buf_res.wifi_ok;

  // a stored credential byte means no byte of this stream was dropped yet
  a_cred_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == wrcp_pkg::EV_CRED_BYTE |-> !res_o.cred_overflow)
    else $error("credential byte stored after overflow");

  a_ok_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == wrcp_pkg::EV_OK |-> res_o.wifi_ok)
    else $error("ok word without ready flag");

  a_recover_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == wrcp_pkg::EV_RECOVER |-> !res_o.wifi_ok)
    else $error("recovery word with ready flag still set");

  a_setting_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.event_res == wrcp_pkg::EV_SET_DONE
    |-> res_o.setting_code != 5'd0 && res_o.value_length != 2'd0)
    else $error("setting word without code or length");

endmodule
